/* rtl/mlfq_pkg.sv */
`default_nettype none
package mlfq_pkg;

  localparam int LEVELS      = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int PID_BITS    = 4;

  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int TSUM_W  = QPTR_W + 1;
  localparam int ADDR_W  = LVL_W + QPTR_W;
  localparam int MEM_DEPTH = LEVELS << QPTR_W;
  localparam int LIM_W   = (LEVELS > 4) ? LEVELS : 4;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ADMIT  = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [PID_BITS-1:0] proc_id;
    logic [2:0]          admit_level;
  } in_t;

  typedef struct packed {
    logic                running_valid;
    logic [PID_BITS-1:0] running_pid;
    logic [2:0]          running_level;
    logic [3:0]          slice_used;
    logic                preempted;
    logic [PID_BITS-1:0] preempted_pid;
    logic                admit_dropped;
  } out_t;

  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [PID_BITS-1:0] wdata;
    logic                re;
    logic [ADDR_W-1:0]   raddr;
  } mem_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_LOAD
  } state_t;

endpackage
`default_nettype wire

/* rtl/mlfq_qmem.sv */
`default_nettype none
module mlfq_qmem (
  input  wire                        clk,
  input  wire  mlfq_pkg::mem_req_t   req,
  output logic [mlfq_pkg::PID_BITS-1:0] rdata
);
  import mlfq_pkg::*;

  logic [PID_BITS-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/mlfq_scheduler_top.sv */
`default_nettype none
// Path through the states: admit, finish and a tick that only counts end in exec;
// a tick that dispatches goes from exec through read and load (exec and read alone
// when every queue turns out empty).
// One command at a time: busy is low again in the cycle that shows done, and no new
// command is taken while busy; the queue memory read is registered, hence the load state.
// The result is shown for one cycle with done and cannot be stalled.
// Reset (rst, synchronous) empties all queues and leaves the block idle, level 1.
module mlfq_scheduler_top (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire  mlfq_pkg::in_t  cmd_in,
  output logic                 busy,
  output logic                 done,
  output mlfq_pkg::out_t       result
);
  import mlfq_pkg::*;

  state_t              state, state_next;
  in_t                 cmd, cmd_next;
  logic                running, running_next;
  logic [PID_BITS-1:0] cur_pid, cur_pid_next;
  logic [2:0]          cur_level, cur_level_next;
  logic [3:0]          slice, slice_next;
  logic                pre, pre_next;
  logic [PID_BITS-1:0] pre_pid, pre_pid_next;
  logic                dropped, dropped_next;
  logic                done_next;
  logic [QPTR_W-1:0]   head [LEVELS];
  logic [QPTR_W-1:0]   head_next [LEVELS];
  logic [CNT_W-1:0]    fill [LEVELS];
  logic [CNT_W-1:0]    fill_next [LEVELS];

  mem_req_t            mreq;
  logic [PID_BITS-1:0] rdata;

  logic                push_en;
  logic [LVL_W-1:0]    push_idx;
  logic                push_full;
  logic [TSUM_W-1:0]   tail_sum;
  logic [QPTR_W-1:0]   tail;
  logic [2:0]          lv_c;
  logic [LIM_W-1:0]    limit;
  logic [LVL_W-1:0]    dem_idx;
  logic                adm_ok;
  logic [LVL_W-1:0]    adm_idx;
  logic                found;
  logic [LVL_W-1:0]    q;

  mlfq_qmem u_qmem (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  // clamp the running level, then derive slice limit, demotion target and admission index
  always_comb begin
    lv_c = cur_level;
    if (cur_level == 3'd0) begin
      lv_c = 3'd1;
    end else if ({1'b0, cur_level} > 4'(LEVELS)) begin
      lv_c = 3'(LEVELS);
    end
    limit   = LIM_W'(1) << (lv_c - 3'd1);
    dem_idx = ({1'b0, lv_c} < 4'(LEVELS)) ? LVL_W'(lv_c) : LVL_W'(lv_c - 3'd1);
    adm_ok  = (cmd.admit_level != 3'd0) && ({1'b0, cmd.admit_level} <= 4'(LEVELS));
    adm_idx = adm_ok ? LVL_W'(cmd.admit_level - 3'd1) : '0;
  end

  // lowest-index (highest-priority, level 1 first) non-empty queue
  always_comb begin
    found = 1'b0;
    q     = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (fill[i] != '0) begin
        found = 1'b1;
        q     = LVL_W'(i);
      end
    end
  end

  always_comb begin
    push_full = (fill[push_idx] == CNT_W'(QUEUE_DEPTH));
    tail_sum  = TSUM_W'(head[push_idx]) + TSUM_W'(fill[push_idx]);
    if (tail_sum >= TSUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - TSUM_W'(QUEUE_DEPTH);
    end
    tail = QPTR_W'(tail_sum);
  end

  always_comb begin
    state_next     = state;
    cmd_next       = cmd;
    running_next   = running;
    cur_pid_next   = cur_pid;
    cur_level_next = cur_level;
    slice_next     = slice;
    pre_next       = pre;
    pre_pid_next   = pre_pid;
    dropped_next   = dropped;
    done_next      = 1'b0;
    head_next      = head;
    fill_next      = fill;
    mreq           = '0;
    push_en        = 1'b0;
    push_idx       = adm_idx;

    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd_next     = cmd_in;
          pre_next     = 1'b0;
          pre_pid_next = '0;
          dropped_next = 1'b0;
          state_next   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd.opcode)
          OP_TICK: begin
            if (running) begin
              if (LIM_W'(slice) >= limit) begin
                // demote and requeue, then dispatch from the updated queues
                pre_next     = 1'b1;
                pre_pid_next = cur_pid;
                running_next = 1'b0;
                push_en      = 1'b1;
                push_idx     = dem_idx;
                state_next   = ST_READ;
              end else begin
                slice_next = slice + 4'd1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
              end
            end else begin
              state_next = ST_READ;
            end
          end
          OP_ADMIT: begin
            push_en      = 1'b1;
            dropped_next = push_full;
            done_next    = 1'b1;
            state_next   = ST_IDLE;
          end
          OP_FINISH: begin
            if (running) begin
              running_next   = 1'b0;
              cur_pid_next   = '0;
              cur_level_next = 3'd1;
              slice_next     = '0;
            end
            done_next  = 1'b1;
            state_next = ST_IDLE;
          end
          default: begin
            done_next  = 1'b1;
            state_next = ST_IDLE;
          end
        endcase
        if (push_en && !push_full) begin
          mreq.we             = 1'b1;
          mreq.waddr          = {push_idx, tail};
          mreq.wdata          = (cmd.opcode == OP_TICK) ? cur_pid : cmd.proc_id;
          fill_next[push_idx] = fill[push_idx] + CNT_W'(1);
        end
      end
      ST_READ: begin
        if (found) begin
          mreq.re        = 1'b1;
          mreq.raddr     = {q, head[q]};
          head_next[q]   = (head[q] == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head[q] + QPTR_W'(1);
          fill_next[q]   = fill[q] - CNT_W'(1);
          cur_level_next = 3'(q) + 3'd1;
          slice_next     = 4'd1;
          running_next   = 1'b1;
          state_next     = ST_LOAD;
        end else begin
          if (pre) begin
            cur_pid_next   = '0;
            cur_level_next = 3'd1;
            slice_next     = '0;
          end
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_LOAD: begin
        cur_pid_next = rdata;
        done_next    = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      running   <= 1'b0;
      cur_pid   <= '0;
      cur_level <= 3'd1;
      slice     <= '0;
      pre       <= 1'b0;
      pre_pid   <= '0;
      dropped   <= 1'b0;
      done      <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      state     <= state_next;
      running   <= running_next;
      cur_pid   <= cur_pid_next;
      cur_level <= cur_level_next;
      slice     <= slice_next;
      pre       <= pre_next;
      pre_pid   <= pre_pid_next;
      dropped   <= dropped_next;
      done      <= done_next;
      head      <= head_next;
      fill      <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    result.running_valid = running;
    result.running_pid   = running ? cur_pid : '0;
    result.running_level = cur_level;
    result.slice_used    = running ? slice : '0;
    result.preempted     = pre;
    result.preempted_pid = pre_pid;
    result.admit_dropped = dropped;
  end

endmodule
`default_nettype wire

/* verif/mlfq_scheduler_top_test.sv */
`default_nettype none
module mlfq_scheduler_top_test;
  import mlfq_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 850;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX = 10;

  // Shadow copy of the scheduler: queues, running registers and the expected result words.
  class sched_shadow;
    logic [PID_BITS-1:0] queue_mem[LEVELS][QUEUE_DEPTH];
    int head[LEVELS];
    int fill[LEVELS];
    bit running;
    logic [PID_BITS-1:0] run_pid;
    int run_level;
    int slice;
    out_t expected_state_q[$];
    int mismatches;

    function new();
      for (int q = 0; q < LEVELS; q++) begin
        head[q] = 0;
        fill[q] = 0;
      end
      running = 1'b0;
      run_pid = '0;
      run_level = 1;
      slice = 0;
      mismatches = 0;
    endfunction

    function bit enqueue(int q, logic [PID_BITS-1:0] pid);
      if (fill[q] >= QUEUE_DEPTH) return 1'b0;
      queue_mem[q][(head[q] + fill[q]) % QUEUE_DEPTH] = pid;
      fill[q]++;
      return 1'b1;
    endfunction

    // Take the head of the lowest-numbered (highest-priority) non-empty level.
    function bit dispatch();
      for (int q = 0; q < LEVELS; q++) begin
        if (fill[q] != 0) begin
          run_pid = queue_mem[q][head[q]];
          head[q] = (head[q] + 1) % QUEUE_DEPTH;
          fill[q]--;
          run_level = q + 1;
          slice = 1;
          running = 1'b1;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_command(in_t c);
      out_t exp_word;
      int lvl;
      int next_lvl;
      exp_word = '0;
      case (c.opcode)
        OP_TICK: begin
          if (running) begin
            if (slice >= (1 << (run_level - 1))) begin
              next_lvl = (run_level < LEVELS) ? run_level + 1 : run_level;
              exp_word.preempted = 1'b1;
              exp_word.preempted_pid = run_pid;
              void'(enqueue(next_lvl - 1, run_pid));
              running = 1'b0;
              if (!dispatch()) begin
                run_pid = '0;
                run_level = 1;
                slice = 0;
              end
            end else begin
              slice++;
            end
          end else begin
            void'(dispatch());
          end
        end
        OP_ADMIT: begin
          lvl = c.admit_level;
          if (lvl < 1 || lvl > LEVELS) lvl = 1;
          if (!enqueue(lvl - 1, c.proc_id)) exp_word.admit_dropped = 1'b1;
        end
        OP_FINISH: begin
          if (running) begin
            running = 1'b0;
            run_pid = '0;
            run_level = 1;
            slice = 0;
          end
        end
        default: ;
      endcase
      exp_word.running_valid = running;
      exp_word.running_pid = running ? run_pid : '0;
      exp_word.running_level = 3'(run_level);
      exp_word.slice_used = running ? 4'(slice) : 4'd0;
      expected_state_q.push_back(exp_word);
    endfunction

    function void check_result(out_t got);
      out_t exp_word;
      if (expected_state_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: result word with nothing pending: %p", got);
        return;
      end
      exp_word = expected_state_q.pop_front();
      if (got.running_valid !== exp_word.running_valid ||
          got.running_pid !== exp_word.running_pid ||
          got.running_level !== exp_word.running_level ||
          got.slice_used !== exp_word.slice_used ||
          got.preempted !== exp_word.preempted ||
          got.preempted_pid !== exp_word.preempted_pid ||
          got.admit_dropped !== exp_word.admit_dropped) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: result mismatch at %0t: expected %p, got %p", $time, exp_word, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  in_t cmd_in;
  logic busy;
  logic done;
  out_t result;

  sched_shadow shadow;
  int idle_cycles;

  mlfq_scheduler_top u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd_in (cmd_in),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Note accepted commands, check result words, and watch for a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) shadow.note_command(cmd_in);
      if (done) shadow.check_result(result);
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Hold start until the block takes the word; drop start only across a gap.
  task automatic send_cmd(logic [1:0] op, logic [PID_BITS-1:0] pid, logic [2:0] lvl, int gap);
    in_t c;
    c.opcode = op;
    c.proc_id = pid;
    c.admit_level = lvl;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd_in <= c;
    do @(posedge clk); while (busy);
  endtask

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Mostly legal levels, now and then one that folds back to level 1.
  function automatic logic [2:0] pick_level();
    if ($urandom_range(0, 99) < 85) return 3'($urandom_range(1, LEVELS));
    case ($urandom_range(0, 3))
      0: return 3'd0;
      1: return 3'd5;
      2: return 3'd6;
      default: return 3'd7;
    endcase
  endfunction

  initial begin
    int words;
    int style;
    int run_len;
    int r;
    bit quiet;
    logic [2:0] burst_lvl;
    logic [1:0] op;

    shadow = new();
    idle_cycles = 0;
    rst <= 1'b1;
    start <= 1'b0;
    cmd_in <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle corners, demotion of a lone process, level folding, extreme ids.
    send_cmd(OP_TICK, 4'd0, 3'd1, 0);
    send_cmd(OP_FINISH, 4'd0, 3'd1, 0);
    send_cmd(OP_UNUSED, 4'd15, 3'd7, 0);
    send_cmd(OP_ADMIT, 4'd15, 3'd1, 0);
    send_cmd(OP_TICK, 4'd0, 3'd0, 0);
    send_cmd(OP_TICK, 4'd0, 3'd0, 1);
    send_cmd(OP_TICK, 4'd0, 3'd0, 0);
    send_cmd(OP_TICK, 4'd0, 3'd0, 2);
    send_cmd(OP_FINISH, 4'd0, 3'd0, 0);
    send_cmd(OP_ADMIT, 4'd0, 3'd0, 0);
    send_cmd(OP_ADMIT, 4'd10, 3'd7, 0);
    send_cmd(OP_ADMIT, 4'd5, 3'd5, 0);
    send_cmd(OP_ADMIT, 4'd3, 3'd4, 0);
    send_cmd(OP_ADMIT, 4'd12, 3'd2, 0);
    send_cmd(OP_ADMIT, 4'd9, 3'd3, 0);
    send_cmd(OP_ADMIT, 4'd6, 3'd6, 0);
    repeat (7) send_cmd(OP_TICK, 4'd0, 3'd0, 0);
    send_cmd(OP_UNUSED, 4'd0, 3'd0, 0);
    send_cmd(OP_FINISH, 4'd0, 3'd0, 0);

    // Random: bursts of admits, runs of ticks, mixed traffic, and queue overfill.
    words = 0;
    while (words < RANDOM_WORDS) begin
      style = $urandom_range(0, 9);
      quiet = ($urandom_range(0, 3) == 0);
      burst_lvl = pick_level();
      if (style <= 2) run_len = $urandom_range(5, 20);
      else if (style <= 5) run_len = $urandom_range(5, 30);
      else if (style <= 8) run_len = $urandom_range(10, 40);
      else run_len = 18;
      for (int i = 0; i < run_len; i++) begin
        if (style <= 2) begin
          send_cmd(OP_ADMIT, 4'($urandom), ($urandom_range(0, 3) == 0) ? pick_level() : burst_lvl,
                   pick_gap(quiet));
        end else if (style <= 5) begin
          send_cmd(OP_TICK, 4'($urandom), 3'($urandom), pick_gap(quiet));
        end else if (style <= 8) begin
          r = $urandom_range(0, 99);
          if (r < 50) op = OP_TICK;
          else if (r < 80) op = OP_ADMIT;
          else if (r < 95) op = OP_FINISH;
          else op = OP_UNUSED;
          send_cmd(op, 4'($urandom), (op == OP_ADMIT) ? pick_level() : 3'($urandom),
                   pick_gap(quiet));
          if (op == OP_UNUSED) words--;
        end else begin
          send_cmd(OP_ADMIT, 4'($urandom), burst_lvl, pick_gap(quiet));
        end
        words++;
      end
    end
    start <= 1'b0;

    while (shadow.expected_state_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
